// ===== rtl/jaes_pkg.sv =====
// Shared types, character codes and keyword table for the JSON array element scanner.
package jaes_pkg;

	// Input transaction: one byte of the array text.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_t;

	// Output transaction: one result per input byte.
	typedef struct packed {
		logic        is_separator;
		logic [15:0] element_index;
		logic        in_selected;
		logic        done_res;
		logic [16:0] element_count;
		logic        not_array;
		logic [2:0]  selected_type;
	} out_t;

	// Character codes
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;

	// Class of the first non-blank byte of the selected element
	localparam logic [2:0] CLS_NONE   = 3'd0;
	localparam logic [2:0] CLS_OBJECT = 3'd1;
	localparam logic [2:0] CLS_ARRAY  = 3'd2;
	localparam logic [2:0] CLS_STRING = 3'd3;
	localparam logic [2:0] CLS_OTHER  = 3'd4;

	// Reported element types
	localparam logic [2:0] TYPE_NULL    = 3'd0;
	localparam logic [2:0] TYPE_BOOLEAN = 3'd1;
	localparam logic [2:0] TYPE_INTEGER = 3'd2;
	localparam logic [2:0] TYPE_FLOAT   = 3'd3;
	localparam logic [2:0] TYPE_STRING  = 3'd4;
	localparam logic [2:0] TYPE_ARRAY   = 3'd5;
	localparam logic [2:0] TYPE_OBJECT  = 3'd6;

	// Keyword slots
	localparam logic [1:0] KW_NULL  = 2'd0;
	localparam logic [1:0] KW_TRUE  = 2'd1;
	localparam logic [1:0] KW_FALSE = 2'd2;

	// Keyword length
	function automatic logic [2:0] kw_len(input logic [1:0] w);
		logic [2:0] r;
		begin
			case (w)
				KW_FALSE: r = 3'd5;
				default:  r = 3'd4;
			endcase
			return r;
		end
	endfunction

	// Keyword character at a position; zero past the end
	function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] p);
		logic [7:0] r;
		begin
			r = 8'h00;
			case (w)
				KW_NULL: begin
					case (p)
						3'd0: r = 8'h6E; // n
						3'd1: r = 8'h75; // u
						3'd2: r = 8'h6C; // l
						3'd3: r = 8'h6C; // l
						default: r = 8'h00;
					endcase
				end
				KW_TRUE: begin
					case (p)
						3'd0: r = 8'h74; // t
						3'd1: r = 8'h72; // r
						3'd2: r = 8'h75; // u
						3'd3: r = 8'h65; // e
						default: r = 8'h00;
					endcase
				end
				KW_FALSE: begin
					case (p)
						3'd0: r = 8'h66; // f
						3'd1: r = 8'h61; // a
						3'd2: r = 8'h6C; // l
						3'd3: r = 8'h73; // s
						3'd4: r = 8'h65; // e
						default: r = 8'h00;
					endcase
				end
				default: r = 8'h00;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== rtl/jaes_core.sv =====
// Per-byte scanner: text state registers and the one-pass next-state and result logic.
module jaes_core #(
	parameter int unsigned     MAX_DEPTH    = 255,
	parameter longint unsigned MAX_ELEMENTS = 65535
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  jaes_pkg::in_t in_item,
	input  logic [15:0]   target_index,
	output jaes_pkg::out_t res
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int XW = (CW > 16) ? CW : 16;
	localparam logic [DW-1:0] DMAX = DW'(MAX_DEPTH);
	localparam logic [CW-1:0] EMAX = CW'(MAX_ELEMENTS);
	localparam logic [DW-1:0] DONE_LVL = DW'(1);

	// text state
	logic [DW-1:0] brace_q, brace_n;
	logic [DW-1:0] bracket_q, bracket_n;
	logic          instr_q, instr_n;
	logic          bs_q;
	logic [1:0]    bpos_q, bpos_n;
	logic [CW-1:0] comma_q, comma_n;
	logic          arr_q, arr_n;
	logic [2:0]    cls_q, cls_n;
	logic [2:0]    alive_q, alive_n;
	logic [2:0]    kpos_q, kpos_n;
	logic          nvalid_q, nvalid_n;
	logic          ndot_q, ndot_n;
	logic          npast_q, npast_n;
	logic          trail_q, trail_n;

	// feed of a keyword/number byte
	logic [2:0] f_alive, f_kpos;
	logic       f_nvalid, f_ndot;
	logic       do_feed;

	logic [7:0]  b;
	logic        last;
	logic        blank;
	logic        is_digit;
	logic        sep, sel, empty;
	logic [CW-1:0] idx_w;
	logic [CW:0]   cnt_ext;

	function automatic logic [2:0] final_type(
		input logic [2:0] cls,
		input logic [2:0] alive,
		input logic [2:0] kpos,
		input logic       nvalid,
		input logic       ndot
	);
		logic [2:0] t;
		begin
			t = jaes_pkg::TYPE_NULL;
			case (cls)
				jaes_pkg::CLS_OBJECT: t = jaes_pkg::TYPE_OBJECT;
				jaes_pkg::CLS_ARRAY:  t = jaes_pkg::TYPE_ARRAY;
				jaes_pkg::CLS_STRING: t = jaes_pkg::TYPE_STRING;
				jaes_pkg::CLS_OTHER: begin
					if ((alive[jaes_pkg::KW_TRUE] && kpos == 3'd4) ||
					    (alive[jaes_pkg::KW_FALSE] && kpos == 3'd5))
						t = jaes_pkg::TYPE_BOOLEAN;
					else if (alive[jaes_pkg::KW_NULL] && kpos == 3'd4)
						t = jaes_pkg::TYPE_NULL;
					else if (nvalid)
						t = ndot ? jaes_pkg::TYPE_FLOAT : jaes_pkg::TYPE_INTEGER;
					else
						t = jaes_pkg::TYPE_NULL;
				end
				default: t = jaes_pkg::TYPE_NULL;
			endcase
			return t;
		end
	endfunction

	assign b    = in_item.text_byte;
	assign last = in_item.is_last;
	assign blank = (b == jaes_pkg::CH_SPACE) || (b == jaes_pkg::CH_TAB) ||
	               (b == jaes_pkg::CH_CR) || (b == jaes_pkg::CH_LF);
	assign is_digit = (b >= jaes_pkg::CH_ZERO) && (b <= jaes_pkg::CH_NINE);

	// keyword and number tracking for one byte
	always_comb begin
		f_alive = alive_q;
		for (int w = 0; w < 3; w++) begin
			if (kpos_q >= jaes_pkg::kw_len(2'(w)) || jaes_pkg::kw_char(2'(w), kpos_q) != b)
				f_alive[w] = 1'b0;
		end
		f_kpos   = (kpos_q == 3'd7) ? kpos_q : kpos_q + 3'd1;
		f_nvalid = nvalid_q;
		f_ndot   = ndot_q;
		if (!is_digit) begin
			if (b == jaes_pkg::CH_MINUS && !npast_q) begin
				f_nvalid = nvalid_q;
			end else if (b == jaes_pkg::CH_DOT && !ndot_q) begin
				f_ndot = 1'b1;
			end else begin
				f_nvalid = 1'b0;
			end
		end
	end

	always_comb begin
		brace_n   = brace_q;
		bracket_n = bracket_q;
		instr_n   = instr_q;
		bpos_n    = (bpos_q == 2'd3) ? bpos_q : bpos_q + 2'd1;
		comma_n   = comma_q;
		arr_n     = arr_q;
		cls_n     = cls_q;
		alive_n   = alive_q;
		kpos_n    = kpos_q;
		nvalid_n  = nvalid_q;
		ndot_n    = ndot_q;
		npast_n   = npast_q;
		trail_n   = trail_q;
		do_feed   = 1'b0;
		sep       = 1'b0;
		sel       = 1'b0;
		idx_w     = '0;

		if (bpos_q == 2'd0) begin
			arr_n = (b == jaes_pkg::CH_LBRACKET);
			if (arr_n)
				bracket_n = DONE_LVL;
		end else if (arr_q) begin
			if (!instr_q) begin
				if (b == jaes_pkg::CH_LBRACE && brace_q < DMAX)
					brace_n = brace_q + 1'b1;
				else if (b == jaes_pkg::CH_RBRACE && brace_q != '0)
					brace_n = brace_q - 1'b1;
				else if (b == jaes_pkg::CH_LBRACKET && bracket_q < DMAX)
					bracket_n = bracket_q + 1'b1;
				else if (b == jaes_pkg::CH_RBRACKET && bracket_q != '0)
					bracket_n = bracket_q - 1'b1;
			end
			if (b == jaes_pkg::CH_QUOTE && !bs_q)
				instr_n = !instr_q;
			idx_w = comma_q;
			// a comma leaves the depths and string flag unchanged
			if (b == jaes_pkg::CH_COMMA && !instr_q && brace_q == '0 && bracket_q == DONE_LVL) begin
				sep = 1'b1;
				if (comma_q < EMAX)
					comma_n = comma_q + 1'b1;
			end else if (XW'(comma_q) == XW'(target_index) &&
			             !(last && b == jaes_pkg::CH_RBRACKET)) begin
				sel = 1'b1;
				if (cls_q == jaes_pkg::CLS_NONE) begin
					if (!blank) begin
						if (b == jaes_pkg::CH_LBRACE)
							cls_n = jaes_pkg::CLS_OBJECT;
						else if (b == jaes_pkg::CH_LBRACKET)
							cls_n = jaes_pkg::CLS_ARRAY;
						else if (b == jaes_pkg::CH_QUOTE)
							cls_n = jaes_pkg::CLS_STRING;
						else begin
							cls_n   = jaes_pkg::CLS_OTHER;
							do_feed = 1'b1;
						end
					end
				end else if (cls_q == jaes_pkg::CLS_OTHER) begin
					if (blank) begin
						trail_n = 1'b1;
					end else if (trail_q) begin
						// inner whitespace spoils keyword and number
						alive_n  = '0;
						nvalid_n = 1'b0;
					end else begin
						do_feed = 1'b1;
					end
				end
			end
		end

		if (do_feed) begin
			alive_n  = f_alive;
			kpos_n   = f_kpos;
			nvalid_n = f_nvalid;
			ndot_n   = f_ndot;
			npast_n  = 1'b1;
		end
	end

	// exactly "[]": closing bracket as the second and last byte
	assign empty   = (bpos_q == 2'd1) && (b == jaes_pkg::CH_RBRACKET);
	assign cnt_ext = {1'b0, comma_n} + 1'b1;

	always_comb begin
		res.is_separator  = sep;
		res.element_index = 16'(idx_w);
		res.in_selected   = sel;
		res.done_res      = last;
		res.not_array     = !arr_n;
		res.element_count = '0;
		res.selected_type = jaes_pkg::TYPE_NULL;
		if (last && arr_n && !empty) begin
			res.element_count = 17'(cnt_ext);
			res.selected_type = final_type(cls_n, alive_n, kpos_n, nvalid_n, ndot_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brace_q   <= '0;
			bracket_q <= '0;
			instr_q   <= 1'b0;
			bs_q      <= 1'b0;
			bpos_q    <= 2'd0;
			comma_q   <= '0;
			arr_q     <= 1'b0;
			cls_q     <= jaes_pkg::CLS_NONE;
			alive_q   <= 3'b111;
			kpos_q    <= 3'd0;
			nvalid_q  <= 1'b1;
			ndot_q    <= 1'b0;
			npast_q   <= 1'b0;
			trail_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				// next byte starts a new text
				brace_q   <= '0;
				bracket_q <= '0;
				instr_q   <= 1'b0;
				bs_q      <= 1'b0;
				bpos_q    <= 2'd0;
				comma_q   <= '0;
				arr_q     <= 1'b0;
				cls_q     <= jaes_pkg::CLS_NONE;
				alive_q   <= 3'b111;
				kpos_q    <= 3'd0;
				nvalid_q  <= 1'b1;
				ndot_q    <= 1'b0;
				npast_q   <= 1'b0;
				trail_q   <= 1'b0;
			end else begin
				brace_q   <= brace_n;
				bracket_q <= bracket_n;
				instr_q   <= instr_n;
				bs_q      <= (b == jaes_pkg::CH_BSLASH);
				bpos_q    <= bpos_n;
				comma_q   <= comma_n;
				arr_q     <= arr_n;
				cls_q     <= cls_n;
				alive_q   <= alive_n;
				kpos_q    <= kpos_n;
				nvalid_q  <= nvalid_n;
				ndot_q    <= ndot_n;
				npast_q   <= npast_n;
				trail_q   <= trail_n;
			end
		end
	end

endmodule

// ===== rtl/json_array_element_scanner_top.sv =====
// Top level of the JSON array element scanner: input stage, scanner core, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | to block  | in_valid / in_stall  | in_data  (jaes_pkg::in_t)
//  out     | from block| out_valid / out_stall| out_data (jaes_pkg::out_t)
//  cfg     | to block  | cfg_we               | cfg_data (target_index)
//
// One byte per cycle while the output is not stalled. A byte accepted into the input
// stage (_s1) moves on when the result register (_s2) is empty or draining; the scanner
// core then updates its text state and the result lands in _s2, raising out_valid.
// Reset clears the stage valids, the text state and target_index.
// A stalled result holds in _s2; the input stage still takes one more
// transaction, after which in_stall rises until the result is taken.
module json_array_element_scanner_top #(
	parameter int unsigned     MAX_DEPTH    = 255,
	parameter longint unsigned MAX_ELEMENTS = 65535
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  jaes_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output jaes_pkg::out_t out_data
);

	logic [15:0]    target_index_q;
	logic           valid_s1;
	jaes_pkg::in_t  item_s1;
	logic           valid_s2;
	jaes_pkg::out_t res_s2;
	jaes_pkg::out_t res_comb;
	logic           advance;
	logic           in_take;

	// the byte in s1 moves on when the result register is empty or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// configuration register; the user must write it only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_index_q <= '0;
		end else if (cfg_we) begin
			target_index_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take)
			item_s1 <= in_data;
	end

	jaes_core #(
		.MAX_DEPTH    (MAX_DEPTH),
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.in_item      (item_s1),
		.target_index (target_index_q),
		.res          (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_comb;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// ===== rtl/jaes_checker.sv =====
// Port-level checker for the JSON array element scanner and its bind.
module jaes_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input jaes_pkg::out_t out_data
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled, full result register
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// count and type appear only on the final byte's result
	a_final_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |->
			out_data.element_count == '0 && out_data.selected_type == jaes_pkg::TYPE_NULL)
		else $error("count or type outside final result");

	// a separator is never content of an element
	a_sep_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_separator |-> !out_data.in_selected)
		else $error("separator marked as selected content");

	// a non-array text yields nothing but the flag
	a_not_array: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.not_array |->
			!out_data.is_separator && !out_data.in_selected &&
			out_data.element_index == '0 && out_data.element_count == '0)
		else $error("non-array text produced element data");

endmodule

bind json_array_element_scanner_top jaes_checker u_jaes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
